// ===== design/irc_message_tokenizer_macros.svh =====
// Assertion macros shared by the checker of the chat-line tokenizer.
// Depends on nothing; include by bare file name.
`ifndef IRC_MESSAGE_TOKENIZER_MACROS_SVH
`define IRC_MESSAGE_TOKENIZER_MACROS_SVH

// Condition in a cycle implies a consequence in the same cycle.
`define IMT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Condition in a cycle implies a consequence in the next cycle.
`define IMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

// ===== design/imt_pkg.sv =====
// Package for the chat-line tokenizer: byte constants, result codes and word types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package imt_pkg;

   localparam int BYTE_W = 8;
   localparam int INDEX_W = 4;
   localparam int MAX_PARAMS_DEFAULT = 16;

   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

   // Role given to each byte of the line.
   typedef enum logic [2:0] {
      ROLE_PREFIX = 3'd0,
      ROLE_SEPARATOR = 3'd1,
      ROLE_COMMAND = 3'd2,
      ROLE_MIDDLE = 3'd3,
      ROLE_TRAIL_COLON = 3'd4,
      ROLE_TRAIL_TEXT = 3'd5,
      ROLE_CR = 3'd6,
      ROLE_IGNORED = 3'd7
   } role_type;

   typedef enum logic [1:0] {
      STATUS_PENDING = 2'd0,
      STATUS_OK = 2'd1,
      STATUS_MALFORMED = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic last_byte;
   } req_word_type;

   typedef struct packed {
      role_type role;
      logic [INDEX_W-1:0] param_index;
      logic token_start;
      logic end_of_message;
      status_type status;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== design/imt_if.sv =====
// Handshake channels of the chat-line tokenizer: byte requests and tagged responses.
// Depends on imt_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface imt_req_if;
   import imt_pkg::*;
   logic valid;
   logic ready;
   logic [BYTE_W-1:0] data_byte;
   logic last_byte;

   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface imt_rsp_if;
   import imt_pkg::*;
   logic valid;
   logic ready;
   role_type role;
   logic [INDEX_W-1:0] param_index;
   logic token_start;
   logic end_of_message;
   status_type status;

   modport source(output valid, output role, output param_index, output token_start,
                  output end_of_message, output status, input ready);
   modport sink(input valid, input role, input param_index, input token_start,
                input end_of_message, input status, output ready);
endinterface
`default_nettype wire

// ===== design/irc_message_tokenizer.sv =====
// Top level of the chat-line tokenizer: input register, parse stage, result register.
// Depends on imt_pkg, imt_if, imt_in_stage, imt_parse and imt_out_stage.
`timescale 1ns / 1ps
`default_nettype none
// The tokenizer takes one byte of a chat-protocol line per word on req, with last_byte
// set on the final byte, and returns one tagged word per byte on rsp, in order. A byte's
// tagged word reaches rsp through the input register and then the result register: the
// byte is held in the input register, and its parse result is then loaded into the
// result register, where it waits until it is taken. The sustained rate is one byte per
// cycle while rsp keeps taking words, set by the parse mode and parameter count, which
// are read and rewritten for each byte. Backpressure on rsp stalls req only when both
// registers are full. The status field is pending on every word but the last of a line,
// which carries ok or malformed; the parser then starts afresh on the next line.
module irc_message_tokenizer #(
   parameter int MAX_PARAMS = imt_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   imt_req_if.sink   req,
   imt_rsp_if.source rsp
);
   import imt_pkg::*;

   req_word_type in_word;
   rsp_word_type parse_result;
   logic         in_valid, out_can_load, advance;

   // A byte moves through the parse stage when the result register can take it.
   assign advance = in_valid && out_can_load;

   imt_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .advance    (advance),
      .word_valid (in_valid),
      .word       (in_word)
   );

   imt_parse #(
      .MAX_PARAMS (MAX_PARAMS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .word    (in_word),
      .result  (parse_result)
   );

   imt_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (parse_result),
      .can_load (out_can_load),
      .rsp      (rsp)
   );

endmodule
`default_nettype wire

// ===== design/imt_in_stage.sv =====
// Input register of the tokenizer: captures one byte word per handshake.
// Depends on imt_pkg and imt_if.
`timescale 1ns / 1ps
`default_nettype none
module imt_in_stage (
   input  logic                clock,
   input  logic                reset,
   imt_req_if.sink             req,
   input  logic                advance,
   output logic                word_valid,
   output imt_pkg::req_word_type word
);
   import imt_pkg::*;

   logic         valid_ff, valid_in;
   req_word_type word_ff, word_in;
   logic         take;

   // A new word may enter when the register is empty or is moving on.
   assign req.ready = !valid_ff || advance;
   assign take = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      word_in = word_ff;
      if (take) begin
         valid_in = 1'b1;
         word_in.data_byte = req.data_byte;
         word_in.last_byte = req.last_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign word_valid = valid_ff;
   assign word = word_ff;

endmodule
`default_nettype wire

// ===== design/imt_parse.sv =====
// Parse stage: line state machine that tags the registered byte and tracks parameters.
// Depends on imt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imt_parse #(
   parameter int MAX_PARAMS = imt_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  imt_pkg::req_word_type word,
   output imt_pkg::rsp_word_type result
);
   import imt_pkg::*;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_PREFIX = 3'd1,
      MODE_PRECMD = 3'd2,
      MODE_CMD = 3'd3,
      MODE_PARAMS = 3'd4,
      MODE_MIDDLE = 3'd5,
      MODE_TRAIL = 3'd6,
      MODE_DONE = 3'd7
   } mode_type;

   // Highest parameter index reported; later parameters share it.
   localparam logic [INDEX_W-1:0] IDX_LIMIT =
      (MAX_PARAMS > (1 << INDEX_W)) ? {INDEX_W{1'b1}} : INDEX_W'(MAX_PARAMS - 1);

   mode_type           mode_ff, mode_in;
   logic [INDEX_W-1:0] count_ff, count_in, count_bumped;
   logic               is_colon, is_space, is_cr, ok;

   assign is_colon = (word.data_byte == CH_COLON);
   assign is_space = (word.data_byte == CH_SPACE);
   assign is_cr = (word.data_byte == CH_CR);
   assign count_bumped = (count_ff < IDX_LIMIT) ? count_ff + INDEX_W'(1) : count_ff;

   // Classify the byte and work out the next mode.
   always_comb begin
      mode_in = mode_ff;
      count_in = count_ff;
      result.role = ROLE_IGNORED;
      result.param_index = '0;
      result.token_start = 1'b0;
      result.end_of_message = word.last_byte;
      result.status = STATUS_PENDING;
      unique case (mode_ff)
         MODE_START: begin
            if (is_colon) begin
               result.role = ROLE_PREFIX;
               mode_in = MODE_PREFIX;
            end else if (is_space) begin
               result.role = ROLE_SEPARATOR;
               mode_in = MODE_PARAMS;
            end else if (is_cr) begin
               result.role = ROLE_CR;
               mode_in = MODE_DONE;
            end else begin
               result.role = ROLE_COMMAND;
               result.token_start = 1'b1;
               mode_in = MODE_CMD;
            end
         end
         MODE_PREFIX: begin
            if (is_space) begin
               result.role = ROLE_SEPARATOR;
               mode_in = MODE_PRECMD;
            end else begin
               result.role = ROLE_PREFIX;
            end
         end
         MODE_PRECMD: begin
            if (is_space) begin
               result.role = ROLE_SEPARATOR;
            end else if (is_cr) begin
               result.role = ROLE_CR;
               mode_in = MODE_DONE;
            end else begin
               result.role = ROLE_COMMAND;
               result.token_start = 1'b1;
               mode_in = MODE_CMD;
            end
         end
         MODE_CMD: begin
            if (is_space) begin
               result.role = ROLE_SEPARATOR;
               mode_in = MODE_PARAMS;
            end else if (is_cr) begin
               result.role = ROLE_CR;
               mode_in = MODE_DONE;
            end else begin
               result.role = ROLE_COMMAND;
            end
         end
         MODE_PARAMS: begin
            if (is_space) begin
               result.role = ROLE_SEPARATOR;
            end else if (is_cr) begin
               result.role = ROLE_CR;
               mode_in = MODE_DONE;
            end else if (is_colon) begin
               result.role = ROLE_TRAIL_COLON;
               result.param_index = count_ff;
               result.token_start = 1'b1;
               mode_in = MODE_TRAIL;
            end else begin
               result.role = ROLE_MIDDLE;
               result.param_index = count_ff;
               result.token_start = 1'b1;
               mode_in = MODE_MIDDLE;
            end
         end
         MODE_MIDDLE: begin
            if (is_space) begin
               result.role = ROLE_SEPARATOR;
               count_in = count_bumped;
               mode_in = MODE_PARAMS;
            end else if (is_cr) begin
               result.role = ROLE_CR;
               count_in = count_bumped;
               mode_in = MODE_DONE;
            end else begin
               result.role = ROLE_MIDDLE;
               result.param_index = count_ff;
            end
         end
         MODE_TRAIL: begin
            if (is_cr) begin
               result.role = ROLE_CR;
               mode_in = MODE_DONE;
            end else begin
               result.role = ROLE_TRAIL_TEXT;
               result.param_index = count_ff;
            end
         end
         default: begin
            // Everything after the CR is ignored.
            result.role = ROLE_IGNORED;
         end
      endcase

      // A line may end between parameters, inside the trailing one or after CR.
      ok = (mode_in == MODE_PARAMS) || (mode_in == MODE_TRAIL) || (mode_in == MODE_DONE);
      if (word.last_byte) begin
         result.status = ok ? STATUS_OK : STATUS_MALFORMED;
         mode_in = MODE_START;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
         count_ff <= '0;
      end else if (advance) begin
         mode_ff <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/imt_out_stage.sv =====
// Result register of the tokenizer: holds one tagged word until it is taken.
// Depends on imt_pkg and imt_if.
`timescale 1ns / 1ps
`default_nettype none
module imt_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  imt_pkg::rsp_word_type result,
   output logic                  can_load,
   imt_rsp_if.source             rsp
);
   import imt_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   // The register frees up in the same cycle that its word is taken.
   assign can_load = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      word_in = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in = result;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.role = word_ff.role;
   assign rsp.param_index = word_ff.param_index;
   assign rsp.token_start = word_ff.token_start;
   assign rsp.end_of_message = word_ff.end_of_message;
   assign rsp.status = word_ff.status;

endmodule
`default_nettype wire

// ===== design/imt_checker.sv =====
// Port checker for the chat-line tokenizer and its bind to the top level.
// Depends on imt_pkg and irc_message_tokenizer_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "irc_message_tokenizer_macros.svh"
module imt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input imt_pkg::role_type             rsp_role,
   input logic [imt_pkg::INDEX_W-1:0]   rsp_param_index,
   input logic                          rsp_token_start,
   input logic                          rsp_end_of_message,
   input imt_pkg::status_type           rsp_status
);
   import imt_pkg::*;

   logic param_role, start_role, rsp_final, rsp_stall;

   assign param_role = (rsp_role == ROLE_MIDDLE) || (rsp_role == ROLE_TRAIL_COLON) ||
                       (rsp_role == ROLE_TRAIL_TEXT);
   assign start_role = (rsp_role == ROLE_COMMAND) || (rsp_role == ROLE_MIDDLE) ||
                       (rsp_role == ROLE_TRAIL_COLON);
   assign rsp_final = (rsp_status != STATUS_PENDING);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A final status appears exactly on the last word of a line.
   `IMT_ASSERT_NOW(a_status_on_eom, clock, reset, rsp_valid, rsp_end_of_message == rsp_final)
   // Only parameter bytes carry a parameter index.
   `IMT_ASSERT_NOW(a_index_role, clock, reset, rsp_valid && !param_role, rsp_param_index == '0)
   // Token starts fall only on command, middle parameter or trailing colon.
   `IMT_ASSERT_NOW(a_start_role, clock, reset, rsp_valid && rsp_token_start, start_role)
   // A stalled result word stays valid and keeps its role and status.
   `IMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable({rsp_role, rsp_status}))

endmodule

bind irc_message_tokenizer imt_checker u_imt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_role           (rsp.role),
   .rsp_param_index    (rsp.param_index),
   .rsp_token_start    (rsp.token_start),
   .rsp_end_of_message (rsp.end_of_message),
   .rsp_status         (rsp.status)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the chat-line tokenizer: drives byte words, predicts each
// tagged result word and compares them in order. Depends on imt_pkg, imt_if and the RTL.
`timescale 1ns / 1ps

import imt_pkg::*;

// Parser modes followed by the predictor.
typedef enum logic [2:0] {
   PM_START,
   PM_PREFIX,
   PM_PRECMD,
   PM_CMD,
   PM_PARAMS,
   PM_MIDDLE,
   PM_TRAIL,
   PM_DONE
} parse_mode_type;

// Predicts the tagged word for each accepted byte and checks the result words against it.
class line_scoreboard;
   localparam int IDX_TOP = (MAX_PARAMS_DEFAULT > 16) ? 15 : MAX_PARAMS_DEFAULT - 1;

   parse_mode_type mode;
   logic [INDEX_W-1:0] count;
   rsp_word_type expected_words[$];
   int errors;

   function new();
      mode = PM_START;
      count = '0;
      errors = 0;
   endfunction

   function void bump_count();
      if (count < IDX_TOP) begin
         count = count + 1'b1;
      end
   endfunction

   // Works out the tagged word for one accepted byte and queues it.
   function void note_byte(logic [BYTE_W-1:0] b, logic last);
      rsp_word_type w;
      w.role = ROLE_IGNORED;
      w.param_index = '0;
      w.token_start = 1'b0;
      w.end_of_message = last;
      w.status = STATUS_PENDING;
      case (mode)
         PM_START: begin
            if (b == CH_COLON) begin
               w.role = ROLE_PREFIX;
               mode = PM_PREFIX;
            end else if (b == CH_SPACE) begin
               w.role = ROLE_SEPARATOR;
               mode = PM_PARAMS;
            end else if (b == CH_CR) begin
               w.role = ROLE_CR;
               mode = PM_DONE;
            end else begin
               w.role = ROLE_COMMAND;
               w.token_start = 1'b1;
               mode = PM_CMD;
            end
         end
         PM_PREFIX: begin
            if (b == CH_SPACE) begin
               w.role = ROLE_SEPARATOR;
               mode = PM_PRECMD;
            end else begin
               w.role = ROLE_PREFIX;
            end
         end
         PM_PRECMD: begin
            if (b == CH_SPACE) begin
               w.role = ROLE_SEPARATOR;
            end else if (b == CH_CR) begin
               w.role = ROLE_CR;
               mode = PM_DONE;
            end else begin
               w.role = ROLE_COMMAND;
               w.token_start = 1'b1;
               mode = PM_CMD;
            end
         end
         PM_CMD: begin
            if (b == CH_SPACE) begin
               w.role = ROLE_SEPARATOR;
               mode = PM_PARAMS;
            end else if (b == CH_CR) begin
               w.role = ROLE_CR;
               mode = PM_DONE;
            end else begin
               w.role = ROLE_COMMAND;
            end
         end
         PM_PARAMS: begin
            if (b == CH_SPACE) begin
               w.role = ROLE_SEPARATOR;
            end else if (b == CH_CR) begin
               w.role = ROLE_CR;
               mode = PM_DONE;
            end else if (b == CH_COLON) begin
               w.role = ROLE_TRAIL_COLON;
               w.param_index = count;
               w.token_start = 1'b1;
               mode = PM_TRAIL;
            end else begin
               w.role = ROLE_MIDDLE;
               w.param_index = count;
               w.token_start = 1'b1;
               mode = PM_MIDDLE;
            end
         end
         PM_MIDDLE: begin
            if (b == CH_SPACE) begin
               w.role = ROLE_SEPARATOR;
               bump_count();
               mode = PM_PARAMS;
            end else if (b == CH_CR) begin
               w.role = ROLE_CR;
               bump_count();
               mode = PM_DONE;
            end else begin
               w.role = ROLE_MIDDLE;
               w.param_index = count;
            end
         end
         PM_TRAIL: begin
            if (b == CH_CR) begin
               w.role = ROLE_CR;
               mode = PM_DONE;
            end else begin
               w.role = ROLE_TRAIL_TEXT;
               w.param_index = count;
            end
         end
         default: begin
            w.role = ROLE_IGNORED;
         end
      endcase

      // The last byte closes the line: a line is sound only between parameters, inside the trailing one or after CR.
      if (last) begin
         w.status = (mode == PM_PARAMS || mode == PM_TRAIL || mode == PM_DONE) ?
                    STATUS_OK : STATUS_MALFORMED;
         mode = PM_START;
         count = '0;
      end
      expected_words = {expected_words, w};
   endfunction

   // Compares one result word with the oldest prediction.
   function void check_word(rsp_word_type got);
      rsp_word_type want;
      bit bad;
      if (expected_words.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: unexpected result word role=%0d idx=%0d start=%0b eom=%0b st=%0d",
                     $realtime, got.role, got.param_index, got.token_start,
                     got.end_of_message, got.status);
         end
         return;
      end
      want = expected_words.pop_front();
      bad = (got.role != want.role) || (got.param_index != want.param_index) ||
            (got.token_start != want.token_start) ||
            (got.end_of_message != want.end_of_message) || (got.status != want.status);
      if (bad) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: mismatch expected role=%0d idx=%0d start=%0b eom=%0b st=%0d",
                     $realtime, want.role, want.param_index, want.token_start,
                     want.end_of_message, want.status);
            $display("%0t:          actual   role=%0d idx=%0d start=%0b eom=%0b st=%0d",
                     $realtime, got.role, got.param_index, got.token_start,
                     got.end_of_message, got.status);
         end
      end
   endfunction

   function int outstanding();
      return expected_words.size();
   endfunction

   // Predictions still waiting at the end are failures too.
   function void close_out();
      if (expected_words.size() != 0) begin
         $display("%0d predicted words never arrived", expected_words.size());
         errors += expected_words.size();
      end
   endfunction
endclass

module tb_top;
   logic clock = 1'b0;
   logic reset;

   imt_req_if req_bus ();
   imt_rsp_if rsp_bus ();

   line_scoreboard sb = new();

   logic [BYTE_W-1:0] line_q[$];
   int bytes_sent = 0;
   bit steady = 1'b0;
   bit hold_request = 1'b0;
   bit hold_active = 1'b0;

   irc_message_tokenizer uut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then long.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) begin
         return 0;
      end
      if (r < 55) begin
         return 0;
      end
      if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // A byte that may sit inside a command or middle token.
   function logic [BYTE_W-1:0] token_byte(bit no_colon);
      logic [BYTE_W-1:0] b;
      do begin
         b = BYTE_W'($urandom_range(0, 255));
      end while (b == CH_SPACE || b == CH_CR || (no_colon && b == CH_COLON));
      return b;
   endfunction

   // A byte biased towards the characters that steer the parser.
   function logic [BYTE_W-1:0] noise_byte();
      case ($urandom_range(0, 5))
         0: return CH_COLON;
         1: return CH_SPACE;
         2: return CH_CR;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Appends one byte to the line being built.
   function void append_byte(logic [BYTE_W-1:0] b);
      line_q = {line_q, b};
   endfunction

   function void push_spaces();
      repeat ($urandom_range(1, 2)) append_byte(CH_SPACE);
   endfunction

   // Builds a mostly well-formed line with random content in line_q.
   function void build_line();
      int nparams;
      logic [BYTE_W-1:0] b;
      line_q.delete();
      if ($urandom_range(0, 3) == 0) begin
         append_byte(CH_COLON);
         repeat ($urandom_range(0, 4)) append_byte(token_byte(1'b0));
         push_spaces();
      end
      // An empty command now and then, otherwise a command token.
      if ($urandom_range(0, 19) != 0) begin
         append_byte(token_byte(1'b1));
         repeat ($urandom_range(0, 3)) append_byte(token_byte(1'b0));
      end
      nparams = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 4) : $urandom_range(10, 20);
      repeat (nparams) begin
         push_spaces();
         append_byte(token_byte(1'b1));
         repeat ($urandom_range(0, 2)) append_byte(token_byte(1'b0));
      end
      if ($urandom_range(0, 1) == 1) begin
         push_spaces();
         append_byte(CH_COLON);
         repeat ($urandom_range(0, 5)) begin
            do begin
               b = ($urandom_range(0, 3) == 0) ? CH_SPACE : BYTE_W'($urandom_range(0, 255));
            end while (b == CH_CR);
            append_byte(b);
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         append_byte(CH_CR);
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) append_byte(BYTE_W'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Offers one byte word, after an optional idle gap, and returns once it is taken.
   task automatic send_byte(logic [BYTE_W-1:0] b, logic last);
      int gap;
      gap = hold_active ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(string s, bit end_line);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i], end_line && (i == s.len() - 1));
      end
   endtask

   task automatic send_queued_line();
      for (int i = 0; i < line_q.size(); i++) begin
         send_byte(line_q[i], i == line_q.size() - 1);
      end
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         int gap;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (150) @(posedge clock);
            hold_active = 1'b0;
         end
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Note every accepted byte word for prediction.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         sb.note_byte(req_bus.data_byte, req_bus.last_byte);
      end
   end

   // Check every accepted result word.
   always @(posedge clock) begin : rsp_monitor
      rsp_word_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.role = rsp_bus.role;
         got.param_index = rsp_bus.param_index;
         got.token_start = rsp_bus.token_start;
         got.end_of_message = rsp_bus.end_of_message;
         got.status = rsp_bus.status;
         sb.check_word(got);
      end
   end

   // Stimulus: reset, directed lines, then random lines.
   initial begin
      int kind;
      int cut;
      int guard;
      bit hold_done;
      hold_done = 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= '0;
      req_bus.last_byte <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Prefix with no space, a lone separator, a lone CR, a command cut short.
      send_text(":", 1'b1);
      send_text(" ", 1'b1);
      send_text("\r", 1'b1);
      send_byte(8'hFF, 1'b1);
      // Prefix then an empty command.
      send_text(":p \r", 1'b1);
      // Command, middle, trailing with a space, CR and an ignored byte after it.
      send_text("C m :t x\r", 1'b0);
      send_byte(8'h00, 1'b1);
      // Line ending inside a middle parameter.
      send_text("C m", 1'b1);

      while (bytes_sent < 1970) begin
         steady = (bytes_sent >= 1300 && bytes_sent < 1500);
         if (!hold_done && bytes_sent >= 800) begin
            hold_request = 1'b1;
            hold_done = 1'b1;
         end
         kind = $urandom_range(0, 99);
         build_line();
         if (kind >= 70 && kind < 85) begin
            // Broken line: a well-formed one cut off early.
            cut = $urandom_range(1, line_q.size());
            while (line_q.size() > cut) void'(line_q.pop_back());
         end else if (kind >= 85) begin
            line_q.delete();
            repeat ($urandom_range(1, 12)) append_byte(noise_byte());
         end
         send_queued_line();
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      // Drain the remaining result words, then allow for the pipeline.
      guard = 0;
      while (sb.outstanding() > 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // Hard limit on the run.
   initial begin
      #3000000;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
